// File: hdl/assert_macros.svh
// Assertion helpers used by the top-level and gain RTL files.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RGMA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RGMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rgma_pkg.sv
package rgma_pkg;

	// Field and datapath widths
	localparam int SAMPLE_W = 32;
	localparam int GAIN_W   = 64;
	localparam int HALF_W   = GAIN_W / 2;
	localparam int PROD_W   = SAMPLE_W + GAIN_W;
	// Floored product is narrowed to this before the bus add; anything
	// outside this range saturates the 32-bit outputs anyway.
	localparam int NARROW_W = 42;
	localparam int SUM_W    = NARROW_W + 1;

	// Fraction bits of the gain format
	localparam int FRAC_LOW  = 15;
	localparam int FRAC_HIGH = 23;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRECISION = 2'd0,
		CFG_START     = 2'd1,
		CFG_STEP      = 2'd2
	} cfg_idx_t;

	// Per-item sideband carried along the pipeline
	typedef struct packed {
		logic [SAMPLE_W-1:0] bus;
		logic                last;
		logic                frac_hi;
	} side_t;

	// Saturate a sum to the signed 32-bit range
	function automatic logic [SAMPLE_W-1:0] sat32(input logic [SUM_W-1:0] v);
		logic [SUM_W-SAMPLE_W:0] top_bits;
		top_bits = v[SUM_W-1:SAMPLE_W-1];
		if (top_bits == '0 || top_bits == '1) begin
			return v[SAMPLE_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	endfunction

endpackage

// File: hdl/ramped_gain_mix_accumulate_unit.sv
// Ramped-gain mix accumulator.
// Input channel (in_valid/in_ready): one source sample, the bus sample it is
// mixed into, and first/last flags. A first item reloads the gain from the
// start register; every transfer then advances the gain by the ramp step.
// Output channel (out_valid/out_ready): floor(bus + in * gain) and the scaled
// product, both saturated to 32 bits, plus a copy of last.
// Configuration channel (cfg_valid/cfg_ready): index 0 precision select
// (15 or 23 fraction bits), 1 start gain, 2 ramp step; always ready, other
// indexes are ignored. Write it only while no items are in flight.
// Pipeline: two stages for the 32x64 multiply (partial products, then
// combine) and one output register for floor, clamp, bus add and
// saturation.
// Throughput: one item per cycle. Each stage moves on when its successor is
// empty or moving, so while the receiver stalls the block still accepts
// items until all three stages are full.
// Reset clears the configuration registers, the running gain and all stage valid flags.
`include "assert_macros.svh"

module ramped_gain_mix_accumulate_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rgma_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rgma_pkg::GAIN_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [rgma_pkg::SAMPLE_W-1:0]  in_sample,
	input  logic signed [rgma_pkg::SAMPLE_W-1:0]  bus_sample,
	input  logic                                  first,
	input  logic                                  last,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [rgma_pkg::SAMPLE_W-1:0]  mixed_sample,
	output logic signed [rgma_pkg::SAMPLE_W-1:0]  product_sample,
	output logic                                  last_out
);
	import rgma_pkg::*;

	logic                      in_fire;
	logic                      en_s1, en_s2, en_s3;
	logic                      valid_s1, valid_s2, valid_q;
	logic signed [GAIN_W-1:0]  gain;
	logic                      frac_hi;
	side_t                     side_in;
	side_t                     side_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic [SAMPLE_W-1:0]       mixed_q;
	logic [SAMPLE_W-1:0]       product_q;
	logic                      last_q;

	// Stage enables: advance when the next stage is empty or advancing
	assign en_s3    = !valid_q || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign in_fire  = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_fire;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_q  <= valid_s2;
		end
	end

	rgma_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_fire (in_fire),
		.first     (first),
		.gain      (gain),
		.frac_hi   (frac_hi)
	);

	assign side_in.bus     = bus_sample;
	assign side_in.last    = last;
	assign side_in.frac_hi = frac_hi;

	rgma_mul u_mul (
		.clk       (clk),
		.en_s1     (en_s1),
		.en_s2     (en_s2),
		.in_sample (in_sample),
		.gain      (gain),
		.side_in   (side_in),
		.prod_s2   (prod_s2),
		.side_s2   (side_s2)
	);

	rgma_out u_out (
		.clk       (clk),
		.en_s3     (en_s3),
		.prod_s2   (prod_s2),
		.side_s2   (side_s2),
		.mixed_q   (mixed_q),
		.product_q (product_q),
		.last_q    (last_q)
	);

	assign out_valid      = valid_q;
	assign mixed_sample   = $signed(mixed_q);
	assign product_sample = $signed(product_q);
	assign last_out       = last_q;

	`RGMA_ASSERT_SAME(a_empty_ready, !valid_s1 && !valid_s2 && !valid_q,
		in_ready, "empty pipeline refused an item")
	`RGMA_ASSERT_NEXT(a_s2_to_out, valid_s2 && en_s3,
		out_valid, "item lost between combine stage and output")
	`RGMA_ASSERT_NEXT(a_fire_fills_s1, in_fire,
		valid_s1, "accepted item did not enter the first stage")

endmodule

// File: hdl/rgma_gain.sv
`include "assert_macros.svh"

module rgma_gain (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [rgma_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rgma_pkg::GAIN_W-1:0]         cfg_data,
	input  logic                                item_fire,
	input  logic                                first,
	output logic signed [rgma_pkg::GAIN_W-1:0]  gain,
	output logic                                frac_hi
);
	import rgma_pkg::*;

	logic                precision_q;
	logic [GAIN_W-1:0]   start_q;
	logic [GAIN_W-1:0]   step_q;
	logic [GAIN_W-1:0]   gain_q;

	// Write configuration registers; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_q <= 1'b0;
			start_q     <= '0;
			step_q      <= '0;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PRECISION: precision_q <= cfg_data[0];
				CFG_START:     start_q     <= cfg_data;
				CFG_STEP:      step_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Reload on the first item of a run, otherwise use the running gain
	assign gain    = first ? $signed(start_q) : $signed(gain_q);
	assign frac_hi = precision_q;

	// Advance the gain by one step per transfer, wrapping modulo 2^64
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
		end else if (item_fire) begin
			gain_q <= gain + step_q;
		end
	end

	`RGMA_ASSERT_NEXT(a_gain_reload, item_fire && first,
		gain_q == $past(start_q + step_q), "gain not reloaded from start value")
	`RGMA_ASSERT_NEXT(a_gain_step, item_fire && !first,
		gain_q == $past(gain_q + step_q), "gain did not advance by one step")
	`RGMA_ASSERT_NEXT(a_gain_hold, !item_fire,
		$stable(gain_q), "gain moved without a transfer")

endmodule

// File: hdl/rgma_mul.sv
module rgma_mul (
	input  logic                                  clk,
	input  logic                                  en_s1,
	input  logic                                  en_s2,
	input  logic signed [rgma_pkg::SAMPLE_W-1:0]  in_sample,
	input  logic signed [rgma_pkg::GAIN_W-1:0]    gain,
	input  rgma_pkg::side_t                       side_in,
	output logic signed [rgma_pkg::PROD_W-1:0]    prod_s2,
	output rgma_pkg::side_t                       side_s2
);
	import rgma_pkg::*;

	localparam int LO_W = SAMPLE_W + HALF_W + 1;
	localparam int HI_W = SAMPLE_W + HALF_W;

	logic signed [SAMPLE_W+HALF_W:0]  pp_lo_s1;
	logic signed [SAMPLE_W+HALF_W-1:0] pp_hi_s1;
	side_t                             side_s1;

	// Stage 1: two partial products of the sample with the 32-bit gain halves (low half taken unsigned)
	always_ff @(posedge clk) begin
		if (en_s1) begin
			pp_lo_s1 <= LO_W'(in_sample) * LO_W'($signed({1'b0, gain[HALF_W-1:0]}));
			pp_hi_s1 <= HI_W'(in_sample) * HI_W'($signed(gain[GAIN_W-1:HALF_W]));
			side_s1  <= side_in;
		end
	end

	// Stage 2: combine the partial products into the exact product
	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= (PROD_W'(pp_hi_s1) <<< HALF_W) + PROD_W'(pp_lo_s1);
			side_s2 <= side_s1;
		end
	end

endmodule

// File: hdl/rgma_out.sv
module rgma_out (
	input  logic                                  clk,
	input  logic                                  en_s3,
	input  logic signed [rgma_pkg::PROD_W-1:0]    prod_s2,
	input  rgma_pkg::side_t                       side_s2,
	output logic [rgma_pkg::SAMPLE_W-1:0]         mixed_q,
	output logic [rgma_pkg::SAMPLE_W-1:0]         product_q,
	output logic                                  last_q
);
	import rgma_pkg::*;

	logic signed [PROD_W-1:0]   floored;
	logic [PROD_W-NARROW_W:0]   top_bits;
	logic [NARROW_W-1:0]        narrow;
	logic [SUM_W-1:0]           narrow_ext;
	logic [SUM_W-1:0]           mix_sum;

	// Floor by arithmetic shift over the selected fraction bits
	assign floored = side_s2.frac_hi ? (prod_s2 >>> FRAC_HIGH) : (prod_s2 >>> FRAC_LOW);

	// Narrow the floored product, clamping values far outside 32 bits
	assign top_bits = floored[PROD_W-1:NARROW_W-1];
	always_comb begin
		if (top_bits == '0 || top_bits == '1) begin
			narrow = floored[NARROW_W-1:0];
		end else if (floored[PROD_W-1]) begin
			narrow = {1'b1, {(NARROW_W-1){1'b0}}};
		end else begin
			narrow = {1'b0, {(NARROW_W-1){1'b1}}};
		end
	end

	// Add the bus sample
	assign narrow_ext = SUM_W'($signed(narrow));
	assign mix_sum    = SUM_W'($signed(side_s2.bus)) + narrow_ext;

	// Hold saturated results until the receiver takes them
	always_ff @(posedge clk) begin
		if (en_s3) begin
			mixed_q   <= sat32(mix_sum);
			product_q <= sat32(narrow_ext);
			last_q    <= side_s2.last;
		end
	end

endmodule
